/* rtl/sqe_pkg.sv */
// ----------------------------------------------------------------------------
// Stack/queue engine package
// Shared constants, request and status codes, and the control and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sqe_pkg;

	// Default number of entries in the store.
	localparam int SQE_DEPTH = 64;
	localparam int DATA_W    = 32;

	// Request codes carried in req_type.
	localparam logic [2:0] REQ_PUSH = 3'd0;
	localparam logic [2:0] REQ_DUMP = 3'd1;
	localparam logic [2:0] REQ_PEEK = 3'd2;
	localparam logic [2:0] REQ_POP  = 3'd3;
	localparam logic [2:0] REQ_SWAP = 3'd4;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NOARG      = 3'd1,
		ST_PEEK_EMPTY = 3'd2,
		ST_POP_EMPTY  = 3'd3,
		ST_SWAP_SHORT = 3'd4,
		ST_FULL       = 3'd5
	} status_t;

	// Which slot the memory read port looks at.
	typedef enum logic [1:0] {
		RD_TOP   = 2'd0,
		RD_BELOW = 2'd1,
		RD_DUMP  = 2'd2
	} rd_sel_t;

	// Which slot and data the memory write port uses.
	typedef enum logic [1:0] {
		WR_PUSH  = 2'd0,
		WR_TOP   = 2'd1,
		WR_BELOW = 2'd2
	} wr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    capture;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    push_commit;
		logic    pop_commit;
		logic    tmp_load;
		logic    dump_next;
		logic    res_load;
		status_t res_status;
		logic    res_use_rd;
		logic    res_dump;
	} sqe_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] req_type;
		logic       present;
		logic       empty;
		logic       full;
		logic       short;
		logic       res_last;
	} sqe_stat_t;

endpackage

/* rtl/sqe_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request into the engine.
// ----------------------------------------------------------------------------
interface sqe_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         req_type;
	logic signed [31:0] push_value;
	logic               value_present;

	modport source (output valid, req_type, push_value, value_present, input ready);
	modport sink (input valid, req_type, push_value, value_present, output ready);
endinterface

/* rtl/sqe_res_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result out of the engine.
// ----------------------------------------------------------------------------
interface sqe_res_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic signed [31:0] read_value;
	logic               value_valid;
	logic               last;

	modport source (output valid, status, read_value, value_valid, last, input ready);
	modport sink (input valid, status, read_value, value_valid, last, output ready);
endinterface

/* rtl/sqe_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that writes the push_at_top mode register.
// ----------------------------------------------------------------------------
interface sqe_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* rtl/sqe_datapath.sv */
// ----------------------------------------------------------------------------
// Stack/queue engine datapath
// Entry memory, bottom index and entry count, captured request, swap
// holding register, dump offset and the result output register.
// ----------------------------------------------------------------------------
module sqe_datapath #(
	parameter int DEPTH = sqe_pkg::SQE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sqe_pkg::sqe_cmd_t   cmd,
	output sqe_pkg::sqe_stat_t  stat,
	input  logic [2:0]          req_type,
	input  logic signed [31:0]  push_value,
	input  logic                value_present,
	input  logic                cfg_we,
	input  logic                cfg_data,
	output logic [2:0]          status,
	output logic signed [31:0]  read_value,
	output logic                value_valid,
	output logic                last
);
	import sqe_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] tmp_q;
	logic [DATA_W-1:0] value_q;
	logic [2:0]        req_type_q;
	logic              present_q;
	logic              push_at_top_q;
	logic [AW-1:0]     bottom_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     dump_idx_q;
	status_t           res_status_q;
	logic [DATA_W-1:0] res_value_q;
	logic              res_valid_q;
	logic              res_last_q;

	logic [CW-1:0]     top_k;
	logic [CW-1:0]     below_k;
	logic [CW-1:0]     dump_k;
	logic [AW-1:0]     top_slot;
	logic [AW-1:0]     below_slot;
	logic [AW-1:0]     dump_slot;
	logic [AW-1:0]     push_slot;
	logic [AW-1:0]     bottom_dec;
	logic              push_on_top;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;

	// Slot that lies k places above the given base, wrapping at DEPTH.
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [AW-1:0] k);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, k};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	// Offsets from the bottom of the entries that requests touch.
	assign top_k      = count_q - CW'(1);
	assign below_k    = count_q - CW'(2);
	assign dump_k     = count_q - CW'(1) - dump_idx_q;
	assign top_slot   = slot(bottom_q, top_k[AW-1:0]);
	assign below_slot = slot(bottom_q, below_k[AW-1:0]);
	assign dump_slot  = slot(bottom_q, dump_k[AW-1:0]);
	assign push_slot  = slot(bottom_q, count_q[AW-1:0]);
	assign bottom_dec = (bottom_q == '0) ? LAST_IDX : bottom_q - AW'(1);
	assign push_on_top = push_at_top_q || (count_q == '0);

	// Memory port address and data selection.
	always_comb begin
		case (cmd.rd_sel)
			RD_BELOW: rd_addr = below_slot;
			RD_DUMP:  rd_addr = dump_slot;
			default:  rd_addr = top_slot;
		endcase
		case (cmd.wr_sel)
			WR_TOP: begin
				wr_addr = top_slot;
				wr_data = rd_q;
			end
			WR_BELOW: begin
				wr_addr = below_slot;
				wr_data = tmp_q;
			end
			default: begin
				wr_addr = push_on_top ? push_slot : bottom_dec;
				wr_data = value_q;
			end
		endcase
	end

	// Entry memory with a registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Captured request fields and the swap holding register.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			value_q   <= push_value;
			present_q <= value_present;
		end
		if (cmd.tmp_load) begin
			tmp_q <= rd_q;
		end
	end

	// Store bookkeeping, mode register and request code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_at_top_q <= 1'b1;
			bottom_q      <= '0;
			count_q       <= '0;
			dump_idx_q    <= '0;
			req_type_q    <= REQ_PUSH;
		end else begin
			if (cfg_we) begin
				push_at_top_q <= cfg_data;
			end
			if (cmd.capture) begin
				req_type_q <= req_type;
				dump_idx_q <= '0;
			end else if (cmd.dump_next) begin
				dump_idx_q <= dump_idx_q + CW'(1);
			end
			if (cmd.push_commit) begin
				count_q <= count_q + CW'(1);
				if (!push_on_top) begin
					bottom_q <= bottom_dec;
				end
			end else if (cmd.pop_commit) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Result output register.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_value_q  <= cmd.res_use_rd ? rd_q : '0;
			res_valid_q  <= cmd.res_use_rd;
			res_last_q   <= cmd.res_dump ? (dump_k == '0) : 1'b1;
		end
	end

	assign status      = res_status_q;
	assign read_value  = res_value_q;
	assign value_valid = res_valid_q;
	assign last        = res_last_q;

	assign stat.req_type = req_type_q;
	assign stat.present  = present_q;
	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q == FULL_CNT);
	assign stat.short    = (count_q < CW'(2));
	assign stat.res_last = res_last_q;

endmodule

/* rtl/sqe_ctrl.sv */
// ----------------------------------------------------------------------------
// Stack/queue engine controller
// State machine that decodes each request and sequences memory reads,
// writes and result loads in the datapath.
// ----------------------------------------------------------------------------
module sqe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                res_valid,
	input  logic                res_ready,
	input  sqe_pkg::sqe_stat_t  stat,
	output sqe_pkg::sqe_cmd_t   cmd
);
	import sqe_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_EXEC  = 8'b0000_0010,
		S_PEEK  = 8'b0000_0100,
		S_SW1   = 8'b0000_1000,
		S_SW2   = 8'b0001_0000,
		S_SW3   = 8'b0010_0000,
		S_DREAD = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and datapath commands.
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.res_status = ST_OK;
		cmd.rd_sel     = RD_TOP;
		cmd.wr_sel     = WR_PUSH;
		req_ready      = 1'b0;
		res_valid      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (stat.req_type)
					REQ_PUSH: begin
						cmd.res_load = 1'b1;
						state_d      = S_OUT;
						if (!stat.present) begin
							cmd.res_status = ST_NOARG;
						end else if (stat.full) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.wr_en       = 1'b1;
							cmd.wr_sel      = WR_PUSH;
							cmd.push_commit = 1'b1;
						end
					end
					REQ_DUMP: begin
						if (stat.empty) begin
							state_d = S_IDLE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_DUMP;
							state_d    = S_DREAD;
						end
					end
					REQ_PEEK: begin
						if (stat.empty) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_PEEK_EMPTY;
							state_d        = S_OUT;
						end else begin
							cmd.rd_en = 1'b1;
							state_d   = S_PEEK;
						end
					end
					REQ_POP: begin
						cmd.res_load = 1'b1;
						state_d      = S_OUT;
						if (stat.empty) begin
							cmd.res_status = ST_POP_EMPTY;
						end else begin
							cmd.pop_commit = 1'b1;
						end
					end
					REQ_SWAP: begin
						if (stat.short) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_SWAP_SHORT;
							state_d        = S_OUT;
						end else begin
							cmd.rd_en = 1'b1;
							state_d   = S_SW1;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_PEEK: begin
				cmd.res_load   = 1'b1;
				cmd.res_use_rd = 1'b1;
				state_d        = S_OUT;
			end
			// Hold the top entry and fetch the one below it.
			S_SW1: begin
				cmd.tmp_load = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = RD_BELOW;
				state_d      = S_SW2;
			end
			S_SW2: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_TOP;
				state_d    = S_SW3;
			end
			S_SW3: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_sel   = WR_BELOW;
				cmd.res_load = 1'b1;
				state_d      = S_OUT;
			end
			S_DREAD: begin
				cmd.res_load   = 1'b1;
				cmd.res_use_rd = 1'b1;
				cmd.res_dump   = 1'b1;
				cmd.dump_next  = 1'b1;
				state_d        = S_OUT;
			end
			S_OUT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					if (stat.res_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_DUMP;
						state_d    = S_DREAD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/stack_queue_engine.sv */
// Push and pop load their result in EXEC, peek in PEEK, and swap in SW3 after SW1 and SW2.
// A dump reads each entry in DREAD through the registered read port of the entry memory,
// and reads the next entry only after the result before it is taken.
// One request is in flight at a time; the next is accepted in the cycle after the last
// result is taken, so back-to-back pushes or pops never overlap.
// Reset clears the controller, bottom index and entry count and sets push_at_top to 1.
// ----------------------------------------------------------------------------
// Stack/queue engine top level
// Bounded store of signed 32-bit words used as a stack or a queue, with
// push, dump, peek, pop and swap requests and error status on each result.
// ----------------------------------------------------------------------------
module stack_queue_engine #(
	parameter int DEPTH = sqe_pkg::SQE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	sqe_req_if.sink   req,
	sqe_res_if.source res,
	sqe_cfg_if.sink   cfg
);
	import sqe_pkg::*;

	sqe_cmd_t  cmd;
	sqe_stat_t stat;
	logic      cfg_we;

	// The mode register always takes a write.
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid;

	sqe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sqe_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_type      (req.req_type),
		.push_value    (req.push_value),
		.value_present (req.value_present),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg.data),
		.status        (res.status),
		.read_value    (res.read_value),
		.value_valid   (res.value_valid),
		.last          (res.last)
	);

endmodule

/* rtl/sqe_checker.sv */
// ----------------------------------------------------------------------------
// Stack/queue engine port checker
// Assertions on the top-level channels, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sqe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  res_status,
	input logic [31:0] res_read_value,
	input logic        res_value_valid,
	input logic        res_last
);
	import sqe_pkg::*;

	// No new request is taken while a result is waiting.
	a_no_req_while_res: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req_ready)
		else $error("request accepted while a result was pending");

	// A result never appears in the cycle right after a request is taken.
	a_res_not_immediate: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !res_valid)
		else $error("result appeared too early after a request");

	// An error result carries no entry and ends its request.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res_status != ST_OK)) |-> (!res_value_valid && res_last))
		else $error("error result with an entry or without last");

	// A stalled result holds its place and payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_status)
			&& $stable(res_read_value) && $stable(res_value_valid) && $stable(res_last)))
		else $error("stalled result changed");

endmodule

bind stack_queue_engine sqe_checker u_sqe_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_status      (res.status),
	.res_read_value  (res.read_value),
	.res_value_valid (res.value_valid),
	.res_last        (res.last)
);

/* sim/stack_queue_engine_tb.sv */
// ----------------------------------------------------------------------------
// Stack/queue engine testbench
// Drives push, dump, peek, pop and swap requests in stack and queue mode,
// predicts every result from a behavioral copy of the store and checks each
// result field by field as it leaves the engine. Both channels idle at random.
// ----------------------------------------------------------------------------
module stack_queue_engine_tb;
	import sqe_pkg::*;

	localparam int STORE_DEPTH   = sqe_pkg::SQE_DEPTH;
	localparam int SETTLE_CYCLES = 12;
	localparam int RUN_LIMIT     = 50_000_000;

	typedef struct {
		status_t            status;
		logic signed [31:0] value;
		logic               value_valid;
		logic               last;
	} result_t;

	logic clk;
	logic arst_n;

	sqe_req_if req_ch ();
	sqe_res_if res_ch ();
	sqe_cfg_if cfg_ch ();

	stack_queue_engine #(
		.DEPTH(STORE_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	// Behavioral copy of the store and of the mode register.
	logic signed [31:0] entry_copy [STORE_DEPTH];
	int                 bottom_slot;
	int                 entry_total;
	logic               push_on_top;

	result_t pending_results[$];
	int      error_count;
	int      burst_left;
	int      stall_mode;
	int      stall_timer;

	// The clock toggles every half period.
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Slot that lies k places above the bottom entry.
	function automatic int slot_above_bottom(int k);
		return (bottom_slot + k) % STORE_DEPTH;
	endfunction

	function automatic void queue_result(status_t st, logic signed [31:0] v, logic vv, logic lst);
		result_t r;
		r.status      = st;
		r.value       = v;
		r.value_valid = vv;
		r.last        = lst;
		pending_results.push_back(r);
	endfunction

	// Apply one accepted request to the store copy and queue what it must return.
	function automatic void apply_request(logic [2:0] kind, logic signed [31:0] v, logic present);
		int                 top_slot;
		int                 below_slot;
		logic signed [31:0] held;
		case (kind)
			REQ_PUSH: begin
				if (!present) begin
					queue_result(ST_NOARG, '0, 1'b0, 1'b1);
				end else if (entry_total >= STORE_DEPTH) begin
					queue_result(ST_FULL, '0, 1'b0, 1'b1);
				end else begin
					if (push_on_top || entry_total == 0) begin
						entry_copy[slot_above_bottom(entry_total)] = v;
					end else begin
						bottom_slot = slot_above_bottom(STORE_DEPTH - 1);
						entry_copy[bottom_slot] = v;
					end
					entry_total++;
					queue_result(ST_OK, '0, 1'b0, 1'b1);
				end
			end
			REQ_DUMP: begin
				for (int i = 0; i < entry_total; i++)
					queue_result(ST_OK, entry_copy[slot_above_bottom(entry_total - 1 - i)], 1'b1,
						i == entry_total - 1);
			end
			REQ_PEEK: begin
				if (entry_total == 0)
					queue_result(ST_PEEK_EMPTY, '0, 1'b0, 1'b1);
				else
					queue_result(ST_OK, entry_copy[slot_above_bottom(entry_total - 1)], 1'b1, 1'b1);
			end
			REQ_POP: begin
				if (entry_total == 0) begin
					queue_result(ST_POP_EMPTY, '0, 1'b0, 1'b1);
				end else begin
					entry_total--;
					queue_result(ST_OK, '0, 1'b0, 1'b1);
				end
			end
			REQ_SWAP: begin
				if (entry_total < 2) begin
					queue_result(ST_SWAP_SHORT, '0, 1'b0, 1'b1);
				end else begin
					top_slot   = slot_above_bottom(entry_total - 1);
					below_slot = slot_above_bottom(entry_total - 2);
					held                   = entry_copy[top_slot];
					entry_copy[top_slot]   = entry_copy[below_slot];
					entry_copy[below_slot] = held;
					queue_result(ST_OK, '0, 1'b0, 1'b1);
				end
			end
			default: begin
				// Unused request codes change nothing and return nothing.
			end
		endcase
	endfunction

	// Present one request and hold it until the engine takes it.
	// Valid stays high on return so that back-to-back requests need no gap.
	task automatic issue_request(logic [2:0] kind, logic signed [31:0] v, logic present);
		req_ch.valid         <= 1'b1;
		req_ch.req_type      <= kind;
		req_ch.push_value    <= v;
		req_ch.value_present <= present;
		do @(posedge clk); while (!req_ch.ready);
		apply_request(kind, v, present);
	endtask

	// The sender works in bursts with random gaps between them.
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	// Stop sending, wait for every queued result, then let in-flight work settle.
	task automatic wait_results_drained();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the mode register while the engine is idle.
	task automatic write_push_mode(logic on_top);
		wait_results_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= on_top;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		push_on_top = on_top;
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2:       return -32'sd78848;
			3:       return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	// One random request; push_pct sets how hard the traffic fills the store.
	task automatic issue_random_request(int push_pct);
		int roll;
		pace_sender();
		if ($urandom_range(0, 99) < push_pct) begin
			issue_request(REQ_PUSH, pick_value(), $urandom_range(0, 15) != 0);
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 32)
				issue_request(REQ_POP, $urandom, 1'($urandom_range(0, 1)));
			else if (roll < 52)
				issue_request(REQ_PEEK, $urandom, 1'($urandom_range(0, 1)));
			else if (roll < 72)
				issue_request(REQ_SWAP, $urandom, 1'($urandom_range(0, 1)));
			else if (roll < 86)
				issue_request(REQ_DUMP, $urandom, 1'($urandom_range(0, 1)));
			else if (roll < 94)
				issue_request(REQ_PUSH, $urandom, 1'b0);
			else
				issue_request(3'($urandom_range(5, 7)), $urandom, 1'($urandom_range(0, 1)));
		end
	endtask

	// Every error case on an empty store, plus the unused request codes.
	task automatic test_empty_errors();
		issue_request(REQ_PEEK, 32'sd0, 1'b0);
		issue_request(REQ_POP, 32'sd0, 1'b0);
		issue_request(REQ_SWAP, 32'sd0, 1'b0);
		issue_request(REQ_DUMP, 32'sd0, 1'b0);
		issue_request(REQ_PUSH, 32'sh7FFF_FFFF, 1'b0);
		issue_request(3'd5, 32'sh8000_0000, 1'b1);
		issue_request(3'd6, -32'sd1, 1'b0);
		issue_request(3'd7, 32'sh5555_AAAA, 1'b1);
		wait_results_drained();
	endtask

	// Stack mode with the extreme values, the special push value and a short swap.
	task automatic test_stack_order();
		write_push_mode(1'b1);
		issue_request(REQ_PUSH, 32'sh7FFF_FFFF, 1'b1);
		issue_request(REQ_PUSH, 32'sh8000_0000, 1'b1);
		issue_request(REQ_SWAP, 32'sd0, 1'b0);
		issue_request(REQ_PEEK, 32'sd0, 1'b0);
		issue_request(REQ_PUSH, -32'sd78848, 1'b1);
		issue_request(REQ_DUMP, 32'sd0, 1'b0);
		issue_request(REQ_POP, 32'sd0, 1'b0);
		issue_request(REQ_POP, 32'sd0, 1'b0);
		issue_request(REQ_SWAP, 32'sd0, 1'b0);
		issue_request(REQ_POP, 32'sd0, 1'b0);
	endtask

	// Queue mode: the second push wraps the bottom below slot zero.
	task automatic test_queue_order();
		write_push_mode(1'b0);
		issue_request(REQ_PUSH, 32'sd1, 1'b1);
		issue_request(REQ_PUSH, -32'sd1, 1'b1);
		issue_request(REQ_PUSH, 32'sd0, 1'b1);
		issue_request(REQ_DUMP, 32'sd0, 1'b0);
		issue_request(REQ_SWAP, 32'sd0, 1'b0);
		issue_request(REQ_PEEK, 32'sd0, 1'b0);
	endtask

	// Fill the store in queue mode, overflow it, dump it whole, then empty it
	// in stack mode.
	task automatic test_full_store();
		while (entry_total < STORE_DEPTH) begin
			pace_sender();
			issue_request(REQ_PUSH, pick_value(), 1'b1);
		end
		issue_request(REQ_PUSH, 32'sd42, 1'b1);
		// A missing integer is reported ahead of the full store.
		issue_request(REQ_PUSH, 32'sd42, 1'b0);
		issue_request(REQ_DUMP, 32'sd0, 1'b0);
		write_push_mode(1'b1);
		issue_request(REQ_PUSH, -32'sd78848, 1'b1);
		issue_request(REQ_SWAP, 32'sd0, 1'b0);
		while (entry_total > 0) begin
			pace_sender();
			if ($urandom_range(0, 4) == 0)
				issue_request(REQ_PEEK, $urandom, 1'b1);
			issue_request(REQ_POP, $urandom, 1'b0);
		end
		issue_request(REQ_POP, 32'sd0, 1'b0);
	endtask

	// Phases of random traffic, each with its own mode and fill pressure.
	task automatic test_random_traffic();
		int fill_pct [5] = '{35, 60, 80, 30, 50};
		for (int phase = 0; phase < 5; phase++) begin
			write_push_mode(phase < 2 ? phase[0] : 1'($urandom_range(0, 1)));
			repeat (60) issue_random_request(fill_pct[phase]);
		end
	endtask

	// The receiver switches among stall patterns of its own.
	always @(posedge clk) begin
		if (stall_timer == 0) begin
			stall_mode  = $urandom_range(0, 3);
			stall_timer = $urandom_range(20, 150);
		end else begin
			stall_timer = stall_timer - 1;
		end
		case (stall_mode)
			0:       res_ch.ready <= 1'b1;
			1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
			2:       res_ch.ready <= (stall_timer % 5 < 2);
			default: res_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	task automatic check_field(string field, logic signed [31:0] want, logic signed [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			error_count++;
		end
	endtask

	// Each accepted result is compared with the oldest queued one.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d value %0d",
					$time, res_ch.status, res_ch.read_value);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, res_ch.status);
				check_field("read_value", want.value, res_ch.read_value);
				check_field("value_valid", want.value_valid, res_ch.value_valid);
				check_field("last", want.last, res_ch.last);
			end
		end
	end

	// Watchdog for a hung run.
	initial begin
		#RUN_LIMIT;
		$display("*** FAILED ***");
		$finish;
	end

	// Main sequence.
	initial begin
		error_count          = 0;
		burst_left           = 0;
		stall_mode           = 0;
		stall_timer          = 0;
		bottom_slot          = 0;
		entry_total          = 0;
		push_on_top          = 1'b1;
		req_ch.valid         = 1'b0;
		req_ch.req_type      = REQ_PUSH;
		req_ch.push_value    = '0;
		req_ch.value_present = 1'b0;
		res_ch.ready         = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.data          = 1'b1;
		arst_n               = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_errors();
		test_stack_order();
		test_queue_order();
		test_full_store();
		test_random_traffic();
		wait_results_drained();

		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
